// ===== rtl/dttt_pkg.sv =====
// Shared types and constants for the delayed task timer table.
// No dependencies; every other file of the block depends on this package.
package dttt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam int ACTION_W  = 2;
  localparam int DELTA_W   = 16;
  localparam int KEY_W     = 32;
  localparam int DELAY_W   = 32;
  localparam int ELAPSED_W = 32;
  localparam int KIND_W    = 3;

  localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADDED     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REMOVED   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [DELAY_W-1:0]   delay;
    logic [ELAPSED_W-1:0] elapsed;
    logic                 rpt;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch request, start the scan read
    logic step;    // retire the current entry of the scan
    logic finish;  // commit the table count and post the final result
  } dttt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;       // table holds no timer
    logic last_entry;  // current scan entry is the last live one
    logic emit_req;    // current entry fires and needs the result slot
    logic out_free;    // result register can take a new result this cycle
  } dttt_stat_t;

endpackage

// ===== rtl/dttt_if.sv =====
// Request and response channel interfaces of the timer table.
// Depends on dttt_pkg for field widths.
interface dttt_req_if;
  logic                          valid;
  logic                          ready;
  logic [dttt_pkg::ACTION_W-1:0] action;
  logic [dttt_pkg::DELTA_W-1:0]  delta_ms;
  logic [dttt_pkg::KEY_W-1:0]    name_key;
  logic [dttt_pkg::DELAY_W-1:0]  delay_ms;
  logic                          periodic;

  modport source (output valid, action, delta_ms, name_key, delay_ms, periodic,
                  input ready);
  modport sink   (input valid, action, delta_ms, name_key, delay_ms, periodic,
                  output ready);
endinterface

interface dttt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [dttt_pkg::KIND_W-1:0]  kind;
  logic [dttt_pkg::KEY_W-1:0]   fired_key;
  logic [dttt_pkg::DELTA_W-1:0] elapsed_ms;
  logic                         last;

  modport source (output valid, kind, fired_key, elapsed_ms, last, input ready);
  modport sink   (input valid, kind, fired_key, elapsed_ms, last, output ready);
endinterface

// ===== rtl/dttt_ctrl.sv =====
// Sequencing state machine of the timer table.
// Depends on dttt_pkg for the command and status structs and action codes.
module dttt_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic [dttt_pkg::ACTION_W-1:0] req_action,
  output logic                          req_ready,
  input  dttt_pkg::dttt_stat_t          stat,
  output dttt_pkg::dttt_cmd_t           cmd
);
  import dttt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          case (req_action)
            ACT_TICK, ACT_REMOVE: state_next = stat.empty ? S_FIN : S_SCAN;
            ACT_ADD:              state_next = S_FIN;
            default:              state_next = S_IDLE;  // unused action: no result
          endcase
        end
      end
      S_SCAN: begin
        // hold while a firing entry waits for the result register
        if (!stat.emit_req || stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.last_entry) state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/dttt_datapath.sv =====
// Timer table memory, scan counters, elapsed update and result register.
// Depends on dttt_pkg; driven by dttt_ctrl through command and status structs.
module dttt_datapath #(
  parameter int TABLE_DEPTH = dttt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dttt_pkg::dttt_cmd_t            cmd,
  output dttt_pkg::dttt_stat_t           stat,
  input  logic [dttt_pkg::ACTION_W-1:0]  req_action,
  input  logic [dttt_pkg::DELTA_W-1:0]   req_delta_ms,
  input  logic [dttt_pkg::KEY_W-1:0]     req_name_key,
  input  logic [dttt_pkg::DELAY_W-1:0]   req_delay_ms,
  input  logic                           req_periodic,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [dttt_pkg::KIND_W-1:0]    rsp_kind,
  output logic [dttt_pkg::KEY_W-1:0]     rsp_fired_key,
  output logic [dttt_pkg::DELTA_W-1:0]   rsp_elapsed_ms,
  output logic                           rsp_last
);
  import dttt_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_DEPTH);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    rd_idx;
  logic [CNT_W-1:0]    wr_idx;
  logic                found;
  logic [ACTION_W-1:0] act;
  logic [DELTA_W-1:0]  delta;
  logic [KEY_W-1:0]    key;
  logic [DELAY_W-1:0]  delay;
  logic                per;

  logic [CNT_W-1:0]     rd_idx_inc;
  logic [ELAPSED_W:0]   sum;
  logic [ELAPSED_W-1:0] e_sat;
  logic                 fire;
  logic                 drop;
  logic                 full;
  logic                 out_free;
  entry_t               upd;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  entry_t               wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [KIND_W-1:0]    final_kind;

  assign rd_idx_inc = rd_idx + CNT_W'(1);
  assign full       = (count == CNT_MAX);
  assign out_free   = !rsp_valid || rsp_ready;

  // saturating elapsed update and fire test on the entry under the scan
  assign sum   = {1'b0, rd_data.elapsed} + {{(ELAPSED_W + 1 - DELTA_W){1'b0}}, delta};
  assign e_sat = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
  assign fire  = (act == ACT_TICK) && (e_sat >= rd_data.delay);

  always_comb begin
    upd = rd_data;
    if (act == ACT_TICK) begin
      upd.elapsed = (fire && rd_data.rpt) ? '0 : e_sat;
      drop        = fire && !rd_data.rpt;
    end else begin
      drop = !found && (rd_data.key == key);
    end
  end

  assign stat.empty      = (count == '0);
  assign stat.last_entry = (rd_idx_inc == count);
  assign stat.emit_req   = fire;
  assign stat.out_free   = out_free;

  // single write port: compaction write-back during a scan, append on add
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[IDX_W-1:0];
    wr_data = upd;
    if (cmd.step && !drop) begin
      wr_en = 1'b1;
    end else if (cmd.finish && act == ACT_ADD && !full) begin
      wr_en         = 1'b1;
      wr_addr       = count[IDX_W-1:0];
      wr_data.key     = key;
      wr_data.delay   = delay;
      wr_data.elapsed = '0;
      wr_data.rpt     = per;
    end
  end

  // read one entry ahead of the one being retired
  assign rd_en   = cmd.accept || cmd.step;
  assign rd_addr = cmd.accept ? '0 : rd_idx_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_comb begin
    case (act)
      ACT_TICK:   final_kind = KIND_TICK_DONE;
      ACT_ADD:    final_kind = full ? KIND_FULL : KIND_ADDED;
      ACT_REMOVE: final_kind = found ? KIND_REMOVED : KIND_NOT_FOUND;
      default:    final_kind = KIND_TICK_DONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act    <= req_action;
      delta  <= req_delta_ms;
      key    <= req_name_key;
      delay  <= req_delay_ms;
      per    <= req_periodic;
      rd_idx <= '0;
      wr_idx <= '0;
      found  <= 1'b0;
    end
    if (cmd.step) begin
      rd_idx <= rd_idx_inc;
      if (!drop) wr_idx <= wr_idx + CNT_W'(1);
      if (drop && act == ACT_REMOVE) found <= 1'b1;
    end
    if (cmd.step && fire) begin
      rsp_kind       <= KIND_FIRED;
      rsp_fired_key  <= rd_data.key;
      rsp_elapsed_ms <= delta;
      rsp_last       <= 1'b0;
    end
    if (cmd.finish) begin
      rsp_kind       <= final_kind;
      rsp_fired_key  <= '0;
      rsp_elapsed_ms <= '0;
      rsp_last       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((cmd.step && fire) || cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (cmd.finish) begin
        if (act == ACT_ADD) begin
          if (!full) count <= count + CNT_W'(1);
        end else begin
          count <= wr_idx;
        end
      end
    end
  end

endmodule

// ===== rtl/delayed_task_timer_table.sv =====
// Top level of the delayed task timer table.
// Depends on dttt_pkg, dttt_if, dttt_ctrl and dttt_datapath.
//
// An ordered table of up to TABLE_DEPTH timers, each holding a name key, a
// delay, a saturating 32-bit elapsed count and a repeat flag. Send a request
// transaction with action tick (add delta_ms to every timer), add (append a
// timer) or remove (delete the first timer whose key matches). A tick answers
// with one fired transaction per expiring timer, in table order, carrying the
// timer key and the delta, followed by a tick done transaction with last set;
// periodic timers restart at zero, one-shot timers leave the table and the
// remaining entries close up in order. Add answers added or table full;
// remove answers removed or not found; both set last. Action 3 is dropped
// with no response. An add goes straight to its final result. A tick or a
// remove walks the table memory (one read and one write port) one entry per
// cycle, with a one-entry read-ahead, and compacts it in the same pass; the
// walk holds while a firing entry waits for the output register to drain on
// rsp.ready, and the final result waits for it likewise. One request is in
// flight at a time; a new request is taken as soon as the previous final
// transaction sits in the output register, even while it still waits to
// be taken. The table needs no clearing pass: only entries below the live
// count are ever used.
module delayed_task_timer_table #(
  parameter int TABLE_DEPTH = dttt_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  dttt_req_if.sink  req,
  dttt_rsp_if.source rsp
);
  import dttt_pkg::*;

  dttt_cmd_t  cmd;
  dttt_stat_t stat;

  // sequencer: takes requests, walks the scan, posts the final transaction
  dttt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_action (req.action),
    .req_ready  (req.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // table memory, elapsed arithmetic and result register
  dttt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_action     (req.action),
    .req_delta_ms   (req.delta_ms),
    .req_name_key   (req.name_key),
    .req_delay_ms   (req.delay_ms),
    .req_periodic   (req.periodic),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_kind       (rsp.kind),
    .rsp_fired_key  (rsp.fired_key),
    .rsp_elapsed_ms (rsp.elapsed_ms),
    .rsp_last       (rsp.last)
  );

endmodule

// ===== rtl/dttt_checker.sv =====
// Port-level checks for the timer table, bound to the top level.
// Depends on dttt_pkg for result kind codes.
module dttt_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [dttt_pkg::KIND_W-1:0]  rsp_kind,
  input logic [dttt_pkg::KEY_W-1:0]   rsp_fired_key,
  input logic [dttt_pkg::DELTA_W-1:0] rsp_elapsed_ms,
  input logic                         rsp_last
);
  import dttt_pkg::*;

  // no response transaction right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // a stalled response holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_fired_key) && $stable(rsp_elapsed_ms) && $stable(rsp_last))
    else $error("stalled response changed");

  // fired transactions never close a request; every other kind does
  a_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_last == (rsp_kind != KIND_FIRED)))
    else $error("last flag does not match kind");

  // only fired transactions carry a key and a delta
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_kind != KIND_FIRED |-> rsp_fired_key == '0 && rsp_elapsed_ms == '0)
    else $error("non-fired response carries payload");

endmodule

bind delayed_task_timer_table dttt_checker u_dttt_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_kind       (rsp.kind),
  .rsp_fired_key  (rsp.fired_key),
  .rsp_elapsed_ms (rsp.elapsed_ms),
  .rsp_last       (rsp.last)
);

// ===== bench/delayed_task_timer_table_tb.sv =====
// Self-checking testbench for the delayed task timer table.
// Depends on dttt_pkg, dttt_if and the delayed_task_timer_table RTL.
// An in-bench timer predictor queues the expected events and checks each response.
module delayed_task_timer_table_tb;
  import dttt_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 310;
  // About 370 requests; even with a full 17-event burst behind every request
  // and the longest stall on each transaction a correct run stays well inside it.
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int LONG_TICKS   = 8;

  // Action 3 is accepted and dropped by the block.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  // Small pool of keys so that adds produce duplicates and removes hit.
  localparam logic [KEY_W-1:0] KEY_POOL_BASE = 32'hC0DE_0000;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [DELTA_W-1:0]  delta_ms;
    logic [KEY_W-1:0]    name_key;
    logic [DELAY_W-1:0]  delay_ms;
    logic                periodic;
  } timer_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   fired_key;
    logic [DELTA_W-1:0] elapsed_ms;
    logic               last;
  } timer_rsp_t;

  logic clk;
  logic rst;

  dttt_req_if req_ch();
  dttt_rsp_if rsp_ch();

  delayed_task_timer_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Mirror of the timer table: only entries below live_count are meaningful.
  logic [KEY_W-1:0]     t_key      [TABLE_DEPTH];
  logic [DELAY_W-1:0]   t_delay    [TABLE_DEPTH];
  logic [ELAPSED_W-1:0] t_elapsed  [TABLE_DEPTH];
  logic                 t_periodic [TABLE_DEPTH];
  int                   live_count;

  // Responses still owed by the block, oldest first.
  timer_rsp_t events_due[$];
  timer_rsp_t due;

  int  mismatches   = 0;
  int  cycle_cnt    = 0;
  int  fired_seen   = 0;
  int  ticks_sent   = 0;
  int  adds_sent    = 0;
  int  removes_sent = 0;
  bit  idle_on;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost response ends here.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Response-side backpressure: drop ready in random bursts while idling is
  // enabled; hold it high otherwise.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready = 1'b0;
    end else if (idle_on && stall_left > 0) begin
      stall_left--;
      rsp_ch.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left   = $urandom_range(0, 5);
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = 1'b1;
    end
  end

  // Compare every accepted response transaction with the oldest expected event.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (events_due.size() == 0) begin
        $error("unexpected response: kind %0d key %0h", rsp_ch.kind, rsp_ch.fired_key);
        mismatches++;
      end else begin
        due = events_due.pop_front();
        if (rsp_ch.kind !== due.kind) begin
          $error("kind: expected %0d, actual %0d", due.kind, rsp_ch.kind);
          mismatches++;
        end
        if (rsp_ch.fired_key !== due.fired_key) begin
          $error("fired_key: expected %0h, actual %0h", due.fired_key, rsp_ch.fired_key);
          mismatches++;
        end
        if (rsp_ch.elapsed_ms !== due.elapsed_ms) begin
          $error("elapsed_ms: expected %0d, actual %0d", due.elapsed_ms, rsp_ch.elapsed_ms);
          mismatches++;
        end
        if (rsp_ch.last !== due.last) begin
          $error("last: expected %0b, actual %0b", due.last, rsp_ch.last);
          mismatches++;
        end
        if (due.kind == KIND_FIRED) fired_seen++;
      end
    end
  end

  function automatic timer_req_t make_req(input logic [ACTION_W-1:0] action,
                                          input logic [DELTA_W-1:0]  delta_ms,
                                          input logic [KEY_W-1:0]    name_key,
                                          input logic [DELAY_W-1:0]  delay_ms,
                                          input logic                periodic);
    timer_req_t rq;
    rq.action   = action;
    rq.delta_ms = delta_ms;
    rq.name_key = name_key;
    rq.delay_ms = delay_ms;
    rq.periodic = periodic;
    return rq;
  endfunction

  function automatic void note_event(input logic [KIND_W-1:0]  kind,
                                     input logic [KEY_W-1:0]   key,
                                     input logic [DELTA_W-1:0] elapsed,
                                     input logic               last);
    timer_rsp_t ev;
    ev.kind       = kind;
    ev.fired_key  = key;
    ev.elapsed_ms = elapsed;
    ev.last       = last;
    events_due.push_back(ev);
  endfunction

  // Advance the mirrored table by one accepted request and queue its events.
  function automatic void timers_apply(input timer_req_t rq);
    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] e;
    bit                   keep;
    int                   w;
    int                   hit;
    w   = 0;
    hit = -1;
    case (rq.action)
      ACT_TICK: begin
        // Walk in table order; fired events come out in that order, and the
        // survivors close up in place behind the write pointer.
        for (int i = 0; i < live_count; i++) begin
          sum  = {1'b0, t_elapsed[i]} + rq.delta_ms;
          e    = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
          keep = 1'b1;
          if (e >= t_delay[i]) begin
            note_event(KIND_FIRED, t_key[i], rq.delta_ms, 1'b0);
            if (t_periodic[i]) e = '0;
            else keep = 1'b0;
          end
          if (keep) begin
            t_key[w]      = t_key[i];
            t_delay[w]    = t_delay[i];
            t_elapsed[w]  = e;
            t_periodic[w] = t_periodic[i];
            w++;
          end
        end
        live_count = w;
        note_event(KIND_TICK_DONE, '0, '0, 1'b1);
      end
      ACT_ADD: begin
        if (live_count >= TABLE_DEPTH) begin
          note_event(KIND_FULL, '0, '0, 1'b1);
        end else begin
          t_key[live_count]      = rq.name_key;
          t_delay[live_count]    = rq.delay_ms;
          t_elapsed[live_count]  = '0;
          t_periodic[live_count] = rq.periodic;
          live_count++;
          note_event(KIND_ADDED, '0, '0, 1'b1);
        end
      end
      ACT_REMOVE: begin
        // Only the first matching key goes.
        for (int i = 0; i < live_count; i++) begin
          if (hit < 0 && t_key[i] == rq.name_key) hit = i;
        end
        if (hit >= 0) begin
          for (int i = hit; i + 1 < live_count; i++) begin
            t_key[i]      = t_key[i + 1];
            t_delay[i]    = t_delay[i + 1];
            t_elapsed[i]  = t_elapsed[i + 1];
            t_periodic[i] = t_periodic[i + 1];
          end
          live_count--;
          note_event(KIND_REMOVED, '0, '0, 1'b1);
        end else begin
          note_event(KIND_NOT_FOUND, '0, '0, 1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  // Drive one request transaction, starting and ending at a falling edge.
  // An optional idle gap goes in front while idling is enabled.
  task automatic send_request(input timer_req_t rq);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_ch.valid    = 1'b1;
    req_ch.action   = rq.action;
    req_ch.delta_ms = rq.delta_ms;
    req_ch.name_key = rq.name_key;
    req_ch.delay_ms = rq.delay_ms;
    req_ch.periodic = rq.periodic;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    // Accepted at this edge: update the mirror now.
    timers_apply(rq);
    case (rq.action)
      ACT_TICK:   ticks_sent++;
      ACT_ADD:    adds_sent++;
      ACT_REMOVE: removes_sent++;
      default: ;
    endcase
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // Add and remove on an empty and a small table, extreme keys and delays,
  // and the dropped action with every field bit set.
  task automatic test_add_remove();
    send_request(make_req(ACT_REMOVE, '0, 32'h0, '0, 1'b0));
    send_request(make_req(ACT_ADD, '0, 32'h0, 32'h0, 1'b0));
    send_request(make_req(ACT_ADD, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(ACT_UNUSED, '1, '1, '1, 1'b1));
    send_request(make_req(ACT_REMOVE, '0, 32'hFFFF_FFFF, '0, 1'b0));
    send_request(make_req(ACT_REMOVE, '0, 32'hFFFF_FFFF, '0, 1'b0));
  endtask

  // A zero-delay timer fires even on a zero-delta tick; then tick an empty table.
  task automatic test_zero_delay();
    send_request(make_req(ACT_TICK, 16'h0000, '0, '0, 1'b0));
    send_request(make_req(ACT_TICK, 16'hFFFF, '0, '0, 1'b0));
  endtask

  // Two timers share a key: remove must take the first one only.
  task automatic test_duplicate_keys();
    send_request(make_req(ACT_ADD, '0, 32'hA5A5_5A5A, 32'd5, 1'b0));
    send_request(make_req(ACT_ADD, '0, 32'hA5A5_5A5A, 32'd0, 1'b1));
    send_request(make_req(ACT_REMOVE, '0, 32'hA5A5_5A5A, '0, 1'b0));
    send_request(make_req(ACT_TICK, 16'd0, '0, '0, 1'b0));
  endtask

  // Fill the table, overflow it once, then fire every entry in one tick
  // for the longest response burst.
  task automatic test_full_and_burst();
    while (live_count < TABLE_DEPTH) begin
      send_request(make_req(ACT_ADD, '0, 32'h100 + live_count, 32'd0, live_count[0]));
    end
    send_request(make_req(ACT_ADD, '0, 32'hDEAD_0001, 32'd1, 1'b0));
    send_request(make_req(ACT_TICK, 16'd3, '0, '0, 1'b0));
  endtask

  // Huge delays: a run of full-delta ticks leaves the counts far below both
  // delays, so neither fires; a zero-delay timer added behind them fires alone.
  task automatic test_long_delays();
    idle_on = 1'b0;
    while (live_count > 0) begin
      send_request(make_req(ACT_REMOVE, '0, t_key[0], '0, 1'b0));
    end
    send_request(make_req(ACT_ADD, '0, 32'h5A70_0001, 32'hFFFF_FFFF, 1'b1));
    send_request(make_req(ACT_ADD, '0, 32'h5A70_0002, 32'hFFFF_FFFE, 1'b0));
    send_request(make_req(ACT_TICK, 16'd1, '0, '0, 1'b0));
    repeat (LONG_TICKS) send_request(make_req(ACT_TICK, 16'hFFFF, '0, '0, 1'b0));
    send_request(make_req(ACT_ADD, '0, 32'h5A70_0003, 32'd0, 1'b0));
    send_request(make_req(ACT_TICK, 16'hFFFF, '0, '0, 1'b0));
  endtask

  // Random mix of ticks, adds and removes. Keys come partly from a small pool
  // so removes hit and duplicates occur; delays are mostly short so timers
  // fire, with some huge ones that pile up and fill the table. Idling is on
  // for most 40-item stretches and off for the final 60 items.
  task automatic test_random_mix();
    timer_req_t rq;
    int served;
    int r;
    int add_cut;
    served  = 0;
    add_cut = 62;
    while (served < RANDOM_ITEMS) begin
      if (served % 40 == 0) begin
        idle_on = ($urandom_range(0, 3) != 0);
        add_cut = ((served / 40) % 2) ? 80 : 62;
      end
      if (RANDOM_ITEMS - served <= 60) idle_on = 1'b0;
      rq = make_req(ACT_UNUSED, DELTA_W'($urandom_range(0, 65535)), $urandom, $urandom,
                    1'($urandom_range(0, 1)));
      r = $urandom_range(0, 99);
      if (r < 3) begin
        rq.action = ACT_UNUSED;
      end else if (r < 33) begin
        rq.action = ACT_TICK;
        case ($urandom_range(0, 5))
          0:       rq.delta_ms = '0;
          1, 2, 3: rq.delta_ms = DELTA_W'($urandom_range(1, 100));
          default: ;
        endcase
      end else if (r < add_cut) begin
        rq.action = ACT_ADD;
        if ($urandom_range(0, 1)) rq.name_key = KEY_POOL_BASE + $urandom_range(0, 7);
        case ($urandom_range(0, 9))
          0, 1:          rq.delay_ms = '0;
          2, 3, 4, 5, 6: rq.delay_ms = $urandom_range(1, 200);
          7:             ;
          default:       rq.delay_ms = {16'hFFFF, rq.delay_ms[15:0]};
        endcase
      end else begin
        rq.action = ACT_REMOVE;
        if (live_count > 0 && $urandom_range(0, 9) < 7) begin
          rq.name_key = t_key[$urandom_range(0, live_count - 1)];
        end else if ($urandom_range(0, 1)) begin
          rq.name_key = KEY_POOL_BASE + $urandom_range(0, 7);
        end
      end
      send_request(rq);
      if (rq.action != ACT_UNUSED) served++;
    end
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.action   = ACT_TICK;
    req_ch.delta_ms = '0;
    req_ch.name_key = '0;
    req_ch.delay_ms = '0;
    req_ch.periodic = 1'b0;
    rsp_ch.ready    = 1'b0;
    idle_on         = 1'b0;
    stall_left      = 0;
    live_count      = 0;

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part runs with idling so stalls hit short transactions too.
    idle_on = 1'b1;
    test_add_remove();
    test_zero_delay();
    test_duplicate_keys();
    test_full_and_burst();
    test_long_delays();
    test_random_mix();

    // Drain: wait for every owed response, then watch for anything stray.
    idle_on = 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);

    $display("tb: sent %0d ticks, %0d adds, %0d removes; %0d timer expiries checked",
             ticks_sent, adds_sent, removes_sent, fired_seen);
    $display("tb: covered full table, 17-event burst, duplicate keys, long delays (%0d cycles)",
             cycle_cnt);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
